[rtl/core/bomc_pkg.sv]
// bomc_pkg: types, codes and constants shared by the box overlap move checker
// depends on nothing; imported by every module under rtl/core
package bomc_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int TAG_W         = 6;
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = 15;
    localparam int CORNER_W      = 18;
    localparam int QCORNER_W     = 19;
    localparam int QUEUE_DEPTH   = 2;

    // request type codes on the input channel
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // status codes on the result channel
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY,
        OP_NOP
    } bomc_op_t;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [TAG_W-1:0]           box_id;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [SIZE_W-1:0]          box_width;
        logic [SIZE_W-1:0]          box_height;
        logic signed [COORD_W-1:0]  anchor_x;
        logic signed [COORD_W-1:0]  anchor_y;
        logic signed [COORD_W-1:0]  step_x;
        logic signed [COORD_W-1:0]  step_y;
    } bomc_in_t;

    typedef struct packed {
        logic [TAG_W-1:0] assigned_tag;
        logic             can_move;
        logic [1:0]       status;
    } bomc_out_t;

    // decoded command handed from front to back
    typedef struct packed {
        bomc_op_t                     op;
        logic [TAG_W-1:0]             box_id;
        logic signed [QCORNER_W-1:0]  min_x;
        logic signed [QCORNER_W-1:0]  max_x;
        logic signed [QCORNER_W-1:0]  min_y;
        logic signed [QCORNER_W-1:0]  max_y;
    } bomc_cmd_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [TAG_W-1:0]            tag;
        logic signed [CORNER_W-1:0]  min_x;
        logic signed [CORNER_W-1:0]  max_x;
        logic signed [CORNER_W-1:0]  min_y;
        logic signed [CORNER_W-1:0]  max_y;
    } bomc_entry_t;

endpackage

[rtl/core/bomc_front.sv]
// bomc_front: accepts request items, decodes the type and computes box corners
// depends on bomc_pkg
module bomc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bomc_pkg::bomc_in_t   s_data,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output bomc_pkg::bomc_cmd_t  cmd_data
);
    import bomc_pkg::*;

    logic                        cmd_valid_reg, cmd_valid_next;
    bomc_cmd_t                   cmd_reg, cmd_next;
    bomc_op_t                    op;
    logic signed [QCORNER_W-1:0] px, py, ox, oy, dx, dy, w, h, min_x, min_y;

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        case (s_data.req_type)
            REQ_INSERT: op = OP_INSERT;
            REQ_REMOVE: op = OP_REMOVE;
            REQ_QUERY:  op = OP_QUERY;
            default:    op = OP_NOP;
        endcase
    end

    // only a query offsets the box by the step
    assign px = QCORNER_W'(s_data.pos_x);
    assign py = QCORNER_W'(s_data.pos_y);
    assign ox = QCORNER_W'(s_data.anchor_x);
    assign oy = QCORNER_W'(s_data.anchor_y);
    assign dx = (op == OP_QUERY) ? QCORNER_W'(s_data.step_x) : '0;
    assign dy = (op == OP_QUERY) ? QCORNER_W'(s_data.step_y) : '0;
    assign w  = QCORNER_W'(s_data.box_width);
    assign h  = QCORNER_W'(s_data.box_height);
    assign min_x = px + dx - ox;
    assign min_y = py + dy - oy;

    always_comb begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
            cmd_next.op     = op;
            cmd_next.box_id = s_data.box_id;
            cmd_next.min_x  = min_x;
            cmd_next.max_x  = min_x + w;
            cmd_next.min_y  = min_y;
            cmd_next.max_y  = min_y + h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

[rtl/core/bomc_queue.sv]
// bomc_queue: short command queue between front and back
// depends on bomc_pkg
module bomc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bomc_pkg::bomc_cmd_t  push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bomc_pkg::bomc_cmd_t  pop_data
);
    import bomc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    bomc_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/bomc_back.sv]
// bomc_back: box table memory, insert/remove/query sequencer and result register
// depends on bomc_pkg
module bomc_back #(
    parameter int MAX_BOXES = bomc_pkg::MAX_BOXES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  bomc_pkg::bomc_cmd_t  cmd_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bomc_pkg::bomc_out_t  m_data
);
    import bomc_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int CMP_W = (CNT_W > TAG_W) ? CNT_W : TAG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, iss_reg, iss_next;
    logic [IDX_W-1:0]  wa_reg, wa_next;
    logic              rd_vld_reg, rd_vld_next, hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;
    bomc_out_t         out_reg, out_next;
    bomc_cmd_t         cmd_reg, cmd_next;

    bomc_entry_t       mem [MAX_BOXES];
    bomc_entry_t       rd_data_reg, mem_wd;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa, mem_ra;

    logic [CMP_W-1:0]  id_ext, cnt_ext;
    logic signed [QCORNER_W-1:0] e_min_x, e_max_x, e_min_y, e_max_y;
    logic              overlap, pop;

    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cmd_ready = pop;

    assign id_ext  = CMP_W'(cmd_data.box_id);
    assign cnt_ext = CMP_W'(cnt_reg);

    assign e_min_x = QCORNER_W'(rd_data_reg.min_x);
    assign e_max_x = QCORNER_W'(rd_data_reg.max_x);
    assign e_min_y = QCORNER_W'(rd_data_reg.min_y);
    assign e_max_y = QCORNER_W'(rd_data_reg.max_y);
    // inclusive overlap: touching edges collide
    assign overlap = !(cmd_reg.max_x < e_min_x || cmd_reg.min_x > e_max_x ||
                       cmd_reg.max_y < e_min_y || cmd_reg.min_y > e_max_y);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        iss_next       = iss_reg;
        wa_next        = wa_reg;
        rd_vld_next    = rd_vld_reg;
        hit_next       = hit_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = rd_data_reg;
        mem_ra         = iss_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && (!out_valid_reg || m_ready)) begin
                    pop         = 1'b1;
                    cmd_next    = cmd_data;
                    out_next    = '0;
                    rd_vld_next = 1'b0;
                    hit_next    = 1'b0;
                    case (cmd_data.op)
                        OP_INSERT: begin
                            out_valid_next = 1'b1;
                            if (cnt_reg >= CNT_W'(MAX_BOXES)) begin
                                out_next.status = STATUS_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                mem_wa       = cnt_reg[IDX_W-1:0];
                                mem_wd.tag   = TAG_W'(cnt_reg);
                                mem_wd.min_x = CORNER_W'(cmd_data.min_x);
                                mem_wd.max_x = CORNER_W'(cmd_data.max_x);
                                mem_wd.min_y = CORNER_W'(cmd_data.min_y);
                                mem_wd.max_y = CORNER_W'(cmd_data.max_y);
                                out_next.assigned_tag = TAG_W'(cnt_reg);
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (id_ext >= cnt_ext) begin
                                out_valid_next  = 1'b1;
                                out_next.status = STATUS_RANGE;
                            end else begin
                                iss_next   = CNT_W'(id_ext + 1'b1);
                                state_next = S_SHIFT;
                            end
                        end
                        OP_QUERY: begin
                            iss_next   = '0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_vld_reg && overlap && (rd_data_reg.tag != cmd_reg.box_id)) begin
                    hit_next = 1'b1;
                end
                if (iss_reg < cnt_reg) begin
                    rd_vld_next = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                end else begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg) begin
                        out_next.can_move = !hit_reg;
                        out_valid_next    = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (rd_vld_reg) begin
                    mem_we = 1'b1;
                    mem_wa = wa_reg;
                end
                if (iss_reg < cnt_reg) begin
                    rd_vld_next = 1'b1;
                    wa_next     = IDX_W'(iss_reg - 1'b1);
                    iss_next    = iss_reg + 1'b1;
                end else begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg) begin
                        cnt_next        = cnt_reg - 1'b1;
                        out_next.status = STATUS_OK;
                        out_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
        iss_reg <= iss_next;
        wa_reg  <= wa_next;
        hit_reg <= hit_next;
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

endmodule

[rtl/core/box_overlap_move_checker.sv]
// box_overlap_move_checker: top level of the box table with move queries
// depends on bomc_pkg, bomc_front, bomc_queue, bomc_back
//
// usage
//   s_ channel: one request item per handshake (insert, remove, move query)
//   m_ channel: exactly one result item per request, in request order
//   both channels are valid/ready; an item moves when valid and ready are high
// flow
//   the front decodes an item and registers it, then a two-entry queue hands
//   it to the back, which owns the table memory
//   insert, rejected or unused request: result set when the back takes it
//   move query: one stored entry read per cycle from the single read port
//   of the table memory
//   remove at slot k: the entries above slot k move down one slot, one entry
//   shifted per cycle
//   the back works on one item at a time and takes the next once the result
//   register is free or being emptied
// reset
//   aresetn low clears the entry count, the queue and all valid flags; the
//   table memory is not cleared, only slots below the count are ever read
// stalls
//   a result waits in the output register while m_ready is low; the front
//   and queue keep taking up to three more items before s_ready drops
module box_overlap_move_checker #(
    parameter int MAX_BOXES = bomc_pkg::MAX_BOXES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bomc_pkg::bomc_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bomc_pkg::bomc_out_t  m_data
);
    import bomc_pkg::*;

    // decoded item from front into queue
    logic      f_valid, f_ready;
    bomc_cmd_t f_cmd;
    // queue head into back
    logic      q_valid, q_ready;
    bomc_cmd_t q_cmd;

    // decode and corner arithmetic
    bomc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_cmd)
    );

    // decouples front from the multi-cycle back
    bomc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    // table, sequencer and result register
    bomc_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
